@@ hw/rtl/pcfx_pkg.sv @@
// Shared constants, types and arithmetic helpers for the pixel color effect block.
`default_nettype none

package pcfx_pkg;

    // Pixel channel width and position counter geometry.
    localparam int PIX_W         = 8;
    localparam int MAX_DIM_BITS  = 12;
    localparam int DIM_W         = MAX_DIM_BITS + 1;
    localparam int CFG_DIM_W     = 13;
    localparam int DIM_CMP_W     = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int POS_W         = 2 * MAX_DIM_BITS;
    localparam int TOTAL_W       = 2 * DIM_W;
    localparam int ZONE_W        = TOTAL_W + 3;

    // Scale factor and product widths.
    localparam int PERCENT_W     = 10;
    localparam int K_W           = PERCENT_W + 1;
    localparam int PROD_W        = PIX_W + K_W;
    localparam int SUM_W         = PIX_W + 2;
    localparam int GAIN20_W      = PIX_W + 5;

    // Configuration port.
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int MODE_W        = 3;
    localparam int CHSEL_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHSEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_TINT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GAIN_UP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GAIN_DOWN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REGION    = 3'd4;

    // Channel slots, in the order blue, green, red.
    localparam int NUM_CH   = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Arithmetic constants.
    localparam int PCT_BASE    = 100;
    localparam int PIX_MAX     = 255;
    localparam int REGION_GAIN = 20;
    // Any product at or above 256 * 100 saturates.
    localparam int SAT_LIMIT   = (PIX_MAX + 1) * PCT_BASE;
    // floor(x / 100) = (x * 20972) >> 21 for every x below 2^15.
    localparam int DIV100_IN_W  = 15;
    localparam int DIV100_SHIFT = 21;
    localparam int DIV100_MUL   = 20972;
    localparam int DIV100_P_W   = 2 * DIV100_IN_W;
    // floor(x / 3) = (x * 683) >> 11 for every x below 1024.
    localparam int DIV3_SHIFT   = 11;
    localparam int DIV3_MUL     = 683;
    localparam int DIV3_P_W     = 2 * SUM_W;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHSEL_W-1:0] chsel;
        logic [K_W-1:0]     k;
        logic [TOTAL_W-1:0] total;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } cfg_t;

    typedef struct packed {
        logic [MAX_DIM_BITS-1:0] col;
        logic [MAX_DIM_BITS-1:0] row;
    } pos_t;

    // Clamps a configured dimension into 1 .. 2^MAX_DIM_BITS.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
        logic [DIM_CMP_W-1:0] dx;
        logic [DIM_CMP_W-1:0] dmax;
        dx   = DIM_CMP_W'(d);
        dmax = DIM_CMP_W'(1) << MAX_DIM_BITS;
        if (dx == '0)
            return DIM_W'(1);
        else if (dx > dmax)
            return DIM_W'(dmax);
        else
            return DIM_W'(dx);
    endfunction

    // floor(p / 100), saturated to the pixel range.
    function automatic logic [PIX_W-1:0] div100_sat(input logic [PROD_W-1:0] p);
        logic [DIV100_P_W-1:0] q;
        q = DIV100_P_W'(p[DIV100_IN_W-1:0]) * DIV100_P_W'(DIV100_MUL);
        if (p >= PROD_W'(SAT_LIMIT))
            return PIX_W'(PIX_MAX);
        else
            return q[DIV100_SHIFT +: PIX_W];
    endfunction

    // floor(s / 3) for a sum of three channels.
    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
        logic [DIV3_P_W-1:0] q;
        q = DIV3_P_W'(s) * DIV3_P_W'(DIV3_MUL);
        return q[DIV3_SHIFT +: PIX_W];
    endfunction

    // c * 20, saturated to the pixel range.
    function automatic logic [PIX_W-1:0] gain20_sat(input logic [PIX_W-1:0] c);
        logic [GAIN20_W-1:0] g;
        g = GAIN20_W'(c) * GAIN20_W'(REGION_GAIN);
        if (g > GAIN20_W'(PIX_MAX))
            return PIX_W'(PIX_MAX);
        else
            return g[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcfx_if.sv @@
// Valid/ready stream interfaces for incoming and processed pixels.
`default_nettype none

interface pcfx_in_if;
    import pcfx_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface pcfx_out_if;
    import pcfx_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pcfx_cfg_regs.sv @@
// Configuration registers with the derived scale factor and image area.
`default_nettype none

module pcfx_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pcfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcfx_pkg::CFG_DATA_W-1:0] cfg_data,
    output pcfx_pkg::cfg_t                    cfg
);
    import pcfx_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [CHSEL_W-1:0]   chsel_reg;
    logic [PERCENT_W-1:0] percent_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [DIM_W-1:0]     width_eff;
    logic [DIM_W-1:0]     height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_TINT;
            chsel_reg   <= '0;
            percent_reg <= '0;
            width_reg   <= CFG_DIM_W'(1);
            height_reg  <= CFG_DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                REG_CHSEL:   chsel_reg   <= cfg_data[CHSEL_W-1:0];
                REG_PERCENT: percent_reg <= cfg_data[PERCENT_W-1:0];
                REG_WIDTH:   width_reg   <= cfg_data[CFG_DIM_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_data[CFG_DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    assign width_eff  = eff_dim(width_reg);
    assign height_eff = eff_dim(height_reg);
    assign total_next = TOTAL_W'(width_eff) * TOTAL_W'(height_eff);

    // The area is registered from the clamped dimensions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= TOTAL_W'(1);
        else
            total_reg <= total_next;
    end

    always_comb
    begin
        cfg.mode   = mode_reg;
        cfg.chsel  = chsel_reg;
        // Gain down scales by percent; every other mode by 100 + percent.
        if (mode_reg == MODE_GAIN_DOWN)
            cfg.k = K_W'(percent_reg);
        else
            cfg.k = K_W'(percent_reg) + K_W'(PCT_BASE);
        cfg.total  = total_reg;
        cfg.width  = width_eff;
        cfg.height = height_eff;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pcfx_position.sv @@
// Column and row counters that track the raster position of each pixel.
`default_nettype none

module pcfx_position (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire pcfx_pkg::cfg_t cfg,
    output pcfx_pkg::pos_t      pos
);
    import pcfx_pkg::*;

    logic [MAX_DIM_BITS-1:0] col_reg;
    logic [MAX_DIM_BITS-1:0] row_reg;
    logic [MAX_DIM_BITS-1:0] col_next;
    logic [MAX_DIM_BITS-1:0] row_next;
    logic [DIM_W-1:0]        col_inc;
    logic [DIM_W-1:0]        row_inc;

    assign col_inc = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);

    // Columns beyond width wrap on the next pixel, rows beyond height on a column wrap.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= cfg.width)
        begin
            col_next = '0;
            if (row_inc >= cfg.height)
                row_next = '0;
            else
                row_next = row_inc[MAX_DIM_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[MAX_DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col = col_reg;
    assign pos.row = row_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pcfx_pipe.sv @@
// Three-stage pixel pipeline: capture, multiply, then scale, clamp and select.
`default_nettype none

module pcfx_pipe (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcfx_pkg::cfg_t cfg,
    input  wire pcfx_pkg::pos_t pos,
    pcfx_in_if.sink             pixel,
    pcfx_out_if.source          result
);
    import pcfx_pkg::*;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;

    // Stage 1: captured pixel and its position.
    logic [PIX_W-1:0]        ch1_reg [NUM_CH];
    logic [MAX_DIM_BITS-1:0] col1_reg;
    logic [MAX_DIM_BITS-1:0] row1_reg;

    // Stage 2: products and the channel sum.
    logic [PIX_W-1:0]  ch2_reg   [NUM_CH];
    logic [PROD_W-1:0] prod2_reg [NUM_CH];
    logic [PROD_W-1:0] prod2_next [NUM_CH];
    logic [POS_W-1:0]  pos2_reg;
    logic [POS_W-1:0]  pos2_next;
    logic [SUM_W-1:0]  sum2_reg;
    logic [SUM_W-1:0]  sum2_next;

    // Stage 3: finished pixel.
    logic [PIX_W-1:0] ch3_reg  [NUM_CH];
    logic [PIX_W-1:0] ch3_next [NUM_CH];

    logic [PIX_W-1:0]  scaled [NUM_CH];
    logic [PIX_W-1:0]  boosted [NUM_CH];
    logic [PIX_W-1:0]  gray;
    logic [ZONE_W-1:0] pos_p1;
    logic [ZONE_W-1:0] pos_x3;
    logic [ZONE_W-1:0] pos_x6;
    logic [ZONE_W-1:0] total_x;
    logic [CHSEL_W-1:0] region_ch;

    assign en3 = !v3_reg || result.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pixel.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= pixel.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pixel.valid)
        begin
            ch1_reg[CH_RED]   <= pixel.red_in;
            ch1_reg[CH_GREEN] <= pixel.green_in;
            ch1_reg[CH_BLUE]  <= pixel.blue_in;
            col1_reg          <= pos.col;
            row1_reg          <= pos.row;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
            prod2_next[i] = PROD_W'(ch1_reg[i]) * PROD_W'(cfg.k);
        pos2_next = POS_W'(col1_reg) * POS_W'(row1_reg);
        sum2_next = SUM_W'(ch1_reg[CH_RED]) + SUM_W'(ch1_reg[CH_GREEN])
                  + SUM_W'(ch1_reg[CH_BLUE]);
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                ch2_reg[i]   <= ch1_reg[i];
                prod2_reg[i] <= prod2_next[i];
            end
            pos2_reg <= pos2_next;
            sum2_reg <= sum2_next;
        end
    end

    // pos < floor(total / k) holds exactly when k * (pos + 1) <= total.
    assign pos_p1  = ZONE_W'(pos2_reg) + ZONE_W'(1);
    assign pos_x3  = (pos_p1 << 1) + pos_p1;
    assign pos_x6  = pos_x3 << 1;
    assign total_x = ZONE_W'(cfg.total);

    always_comb
    begin
        if (pos_x6 <= total_x)
            region_ch = CHSEL_W'(CH_BLUE);
        else if (pos_x3 <= total_x)
            region_ch = CHSEL_W'(CH_RED);
        else
            region_ch = CHSEL_W'(CH_GREEN);
    end

    assign gray = div3(sum2_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            scaled[i]   = div100_sat(prod2_reg[i]);
            boosted[i]  = gain20_sat(ch2_reg[i]);
            ch3_next[i] = ch2_reg[i];
        end
        case (cfg.mode)
            MODE_TINT:
            begin
                // A select code past red leaves the pixel as it is.
                for (int i = 0; i < NUM_CH; i++)
                    if (cfg.chsel == CHSEL_W'(i))
                        ch3_next[i] = scaled[i];
            end
            MODE_GRAY:
            begin
                for (int i = 0; i < NUM_CH; i++)
                    ch3_next[i] = gray;
            end
            MODE_GAIN_UP, MODE_GAIN_DOWN:
            begin
                for (int i = 0; i < NUM_CH; i++)
                    ch3_next[i] = scaled[i];
            end
            MODE_REGION:
            begin
                for (int i = 0; i < NUM_CH; i++)
                    if (region_ch == CHSEL_W'(i))
                        ch3_next[i] = boosted[i];
            end
            default:
            begin
                for (int i = 0; i < NUM_CH; i++)
                    ch3_next[i] = ch2_reg[i];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            for (int i = 0; i < NUM_CH; i++)
                ch3_reg[i] <= ch3_next[i];
        end
    end

    assign result.valid     = v3_reg;
    assign result.red_out   = ch3_reg[CH_RED];
    assign result.green_out = ch3_reg[CH_GREEN];
    assign result.blue_out  = ch3_reg[CH_BLUE];

endmodule

`default_nettype wire

@@ hw/rtl/pixel_color_effect.sv @@
// Top level of the per-pixel color effect block.
//
// The block takes RGB pixels in raster order on the pixel stream and returns one
// processed pixel per input pixel on the result stream, in the same order. Both
// streams use valid/ready; a beat moves at a rising edge where both are high.
// The effect (tint, grayscale, gain up, gain down, region tint) is chosen through
// the write-only configuration port, to be written only while the stream is idle; the block does not enforce it.
//
// Throughput is one pixel per cycle while the receiver holds ready high. An
// accepted pixel passes through a capture register, a register after the channel
// and position multipliers, and the result register after the divide-by-constant,
// clamp and channel select.
//
// When the receiver holds ready low, the result register keeps its beat and the
// two stages behind it still fill, so up to two more pixels are taken before the
// pixel stream sees ready fall.
//
// Reset empties the pipeline, clears the column and row counters and loads the
// register defaults (tint mode, blue channel, zero percent, a 1 by 1 image).
// The image area used by region tint is registered from the dimension registers.
`default_nettype none

module pixel_color_effect (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pcfx_in_if.sink                              pixel,
    pcfx_out_if.source                           result,
    input  wire logic                            cfg_we,
    input  wire logic [pcfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcfx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcfx_pkg::*;

    cfg_t cfg;
    pos_t pos;
    logic accept;

    // The position counters step on every accepted pixel, in every mode.
    assign accept = pixel.valid && pixel.ready;

    pcfx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcfx_position u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .cfg     (cfg),
        .pos     (pos)
    );

    pcfx_pipe u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pos    (pos),
        .pixel  (pixel),
        .result (result)
    );

endmodule

`default_nettype wire

@@ bench/pcfx_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts every processed pixel and compares it with the result stream.
module pcfx_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pcfx_in_if                                   pixel,
    pcfx_out_if                                  result,
    input  wire logic                            cfg_we,
    input  wire logic [pcfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcfx_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                          mismatches,
    output int unsigned                          beats_checked,
    output int unsigned                          pixels_owed
);
    import pcfx_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    logic [MODE_W-1:0]       mode_q;
    logic [CHSEL_W-1:0]      chsel_q;
    logic [PERCENT_W-1:0]    percent_q;
    logic [CFG_DIM_W-1:0]    width_q;
    logic [CFG_DIM_W-1:0]    height_q;
    logic [MAX_DIM_BITS-1:0] col_q;
    logic [MAX_DIM_BITS-1:0] row_q;
    pixel_t                  expected_pixels[$];
    int unsigned             fail_count = 0;
    int unsigned             seen_count = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] d);
        int unsigned dv;
        int unsigned limit;
        dv    = d;
        limit = 1 << MAX_DIM_BITS;
        if (dv == 0)
            return 1;
        return (dv > limit) ? limit : dv;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pix(input int unsigned v);
        return (v > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(v);
    endfunction

    // floor(c * k / 100), saturated.
    function automatic logic [PIX_W-1:0] scale_pix(input logic [PIX_W-1:0] c,
                                                   input int unsigned k);
        int unsigned cv;
        cv = c;
        return clamp_pix((cv * k) / PCT_BASE);
    endfunction

    function automatic pixel_t processed_pixel(input pixel_t p);
        pixel_t      o;
        int unsigned k;
        int unsigned total;
        int unsigned pos;
        int unsigned sum;
        o = p;
        k = PCT_BASE + percent_q;
        case (mode_q)
            MODE_TINT:
                case (chsel_q)
                    CH_BLUE:  o.blue  = scale_pix(p.blue, k);
                    CH_GREEN: o.green = scale_pix(p.green, k);
                    CH_RED:   o.red   = scale_pix(p.red, k);
                    default:  o = p;
                endcase
            MODE_GRAY:
            begin
                sum     = p.red + p.green + p.blue;
                o.red   = PIX_W'(sum / 3);
                o.green = o.red;
                o.blue  = o.red;
            end
            MODE_GAIN_UP:
            begin
                o.red   = scale_pix(p.red, k);
                o.green = scale_pix(p.green, k);
                o.blue  = scale_pix(p.blue, k);
            end
            MODE_GAIN_DOWN:
            begin
                o.red   = scale_pix(p.red, percent_q);
                o.green = scale_pix(p.green, percent_q);
                o.blue  = scale_pix(p.blue, percent_q);
            end
            MODE_REGION:
            begin
                // Bands of the image area: first sixth blue, up to a third red, rest green.
                total = clamp_dim(width_q) * clamp_dim(height_q);
                pos   = col_q * row_q;
                if (pos < total / 6)
                    o.blue = clamp_pix(p.blue * REGION_GAIN);
                else if (pos < total / 3)
                    o.red = clamp_pix(p.red * REGION_GAIN);
                else
                    o.green = clamp_pix(p.green * REGION_GAIN);
            end
            default:
                o = p;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t      taken;
        pixel_t      want;
        int unsigned w;
        int unsigned h;
        if (!rst_n)
        begin
            mode_q    = MODE_TINT;
            chsel_q   = CHSEL_W'(CH_BLUE);
            percent_q = '0;
            width_q   = CFG_DIM_W'(1);
            height_q  = CFG_DIM_W'(1);
            col_q     = '0;
            row_q     = '0;
            expected_pixels.delete();
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                taken.red   = pixel.red_in;
                taken.green = pixel.green_in;
                taken.blue  = pixel.blue_in;
                expected_pixels.push_back(processed_pixel(taken));
                // Raster position moves on in every mode.
                w = clamp_dim(width_q);
                h = clamp_dim(height_q);
                if (col_q + 1 >= w)
                begin
                    col_q = '0;
                    if (row_q + 1 >= h)
                        row_q = '0;
                    else
                        row_q = row_q + 1'b1;
                end
                else
                    col_q = col_q + 1'b1;
            end

            if (cfg_we)
                case (cfg_index)
                    REG_MODE:    mode_q    = cfg_data[MODE_W-1:0];
                    REG_CHSEL:   chsel_q   = cfg_data[CHSEL_W-1:0];
                    REG_PERCENT: percent_q = cfg_data[PERCENT_W-1:0];
                    REG_WIDTH:   width_q   = cfg_data[CFG_DIM_W-1:0];
                    REG_HEIGHT:  height_q  = cfg_data[CFG_DIM_W-1:0];
                    default:     ;
                endcase

            if (result.valid && result.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("result beat %0d with no pixel waiting",
                                              seen_count));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result.red_out !== want.red)
                        report_mismatch($sformatf("beat %0d red_out %0d, expected %0d",
                                                  seen_count, result.red_out, want.red));
                    if (result.green_out !== want.green)
                        report_mismatch($sformatf("beat %0d green_out %0d, expected %0d",
                                                  seen_count, result.green_out, want.green));
                    if (result.blue_out !== want.blue)
                        report_mismatch($sformatf("beat %0d blue_out %0d, expected %0d",
                                                  seen_count, result.blue_out, want.blue));
                end
                seen_count++;
            end
        end
        mismatches    <= fail_count;
        beats_checked <= seen_count;
        pixels_owed   <= expected_pixels.size();
    end

endmodule

@@ bench/pixel_color_effect_test.sv @@
`timescale 1ns / 100ps
// Top of the pixel color effect testbench: clock, reset, stimulus and verdict.
module pixel_color_effect_test;
    import pcfx_pkg::*;

    // One write-enable bit per configuration register, indexed by register.
    localparam int              NUM_REGS   = REG_HEIGHT + 1;
    localparam logic [4:0]      WR_MODE    = 5'(1) << REG_MODE;
    localparam logic [4:0]      WR_CHSEL   = 5'(1) << REG_CHSEL;
    localparam logic [4:0]      WR_PERCENT = 5'(1) << REG_PERCENT;
    localparam logic [4:0]      WR_WIDTH   = 5'(1) << REG_WIDTH;
    localparam logic [4:0]      WR_HEIGHT  = 5'(1) << REG_HEIGHT;
    // Codes the block treats as pass-through.
    localparam int unsigned     CH_NONE    = 3;
    localparam int unsigned     MODE_SPARE = 7;
    localparam int unsigned     RANDOM_PIXELS = 600;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatches;
    int unsigned           beats_checked;
    int unsigned           pixels_owed;
    int unsigned           pixels_sent = 0;
    // Chance, in percent, that the sender or the receiver holds off in a cycle.
    int unsigned           send_idle_pct = 22;
    int unsigned           recv_idle_pct = 54;

    pcfx_in_if  pixel();
    pcfx_out_if result();

    pixel_color_effect i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcfx_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pixel),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_checked (beats_checked),
        .pixels_owed   (pixels_owed)
    );

    always #6 clk = ~clk;

    // The receiver decides its ready for the next edge at every rising edge, so that
    // stalls land on every stage of the pipeline, including while it is full.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Presents one pixel and holds it until the block takes it. Valid stays high
    // into the next call, so back-to-back beats go out when no gap is drawn.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel.valid <= 1'b0;
            @(posedge clk);
        end
        pixel.valid    <= 1'b1;
        pixel.red_in   <= r;
        pixel.green_in <= g;
        pixel.blue_in  <= b;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Registers may only change while the block is empty, so the stream is
    // stopped and every owed result collected before any write goes out.
    // Callers always select at least one register.
    task automatic reconfigure(input logic [4:0] which, input int unsigned mode,
                               input int unsigned chsel, input int unsigned pct,
                               input int unsigned wid, input int unsigned hgt);
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        vals[REG_MODE]    = CFG_DATA_W'(mode);
        vals[REG_CHSEL]   = CFG_DATA_W'(chsel);
        vals[REG_PERCENT] = CFG_DATA_W'(pct);
        vals[REG_WIDTH]   = CFG_DATA_W'(wid);
        vals[REG_HEIGHT]  = CFG_DATA_W'(hgt);
        pixel.valid <= 1'b0;
        while (beats_checked < pixels_sent)
            @(posedge clk);
        for (int idx = 0; idx < NUM_REGS; idx++)
            if (which[idx])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(idx);
                cfg_data  <= vals[idx];
                @(posedge clk);
            end
        cfg_we <= 1'b0;
    endtask

    // Image dimension: mostly small so that the region bands and the counter
    // wrap are exercised often, sometimes zero, the maximum or beyond it.
    function automatic int unsigned pick_dim();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1 << MAX_DIM_BITS;
            2:       return $urandom_range((1 << CFG_DIM_W) - 1, (1 << MAX_DIM_BITS) + 1);
            3:       return $urandom_range(1 << MAX_DIM_BITS, 1);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    initial
    begin
        int unsigned random_sent;
        int unsigned burst;
        int unsigned top;
        int unsigned pct;

        pixel.valid    <= 1'b0;
        pixel.red_in   <= '0;
        pixel.green_in <= '0;
        pixel.blue_in  <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset leaves tint on blue by zero percent, which is the
        // identity, on a 1 by 1 image.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);

        // Tint on red at the largest percent the field holds: saturates quickly.
        reconfigure(WR_MODE | WR_CHSEL | WR_PERCENT, MODE_TINT, CH_RED, 1023, 0, 0);
        send_pixel(8'd200, 8'd60, 8'd20);
        send_pixel(8'd1, 8'd128, 8'd7);

        // The fourth channel code selects nothing, so the pixel passes.
        reconfigure(WR_CHSEL, 0, CH_NONE, 0, 0, 0);
        send_pixel(8'd200, 8'd100, 8'd50);

        // Grayscale, including sums that round down.
        reconfigure(WR_MODE, MODE_GRAY, 0, 0, 0, 0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd1, 8'd1, 8'd0);

        // Gain up by 1000 percent.
        reconfigure(WR_MODE | WR_PERCENT, MODE_GAIN_UP, 0, 1000, 0, 0);
        send_pixel(8'd25, 8'd23, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd1);

        // Gain down to black, then by more than a whole factor.
        reconfigure(WR_MODE | WR_PERCENT, MODE_GAIN_DOWN, 0, 0, 0, 0);
        send_pixel(8'd255, 8'd255, 8'd255);
        reconfigure(WR_PERCENT, 0, 0, 1023, 0, 0);
        send_pixel(8'd255, 8'd3, 8'd40);

        // Region tint on a 3 by 3 image: one full frame covers all three bands,
        // and the counters wrap back to the origin at its end.
        reconfigure(WR_MODE | WR_WIDTH | WR_HEIGHT, MODE_REGION, 0, 0, 3, 3);
        repeat (9) send_pixel(8'd12, 8'd13, 8'd11);

        // Zero dimensions act as 1.
        reconfigure(WR_WIDTH | WR_HEIGHT, 0, 0, 0, 0, 0);
        send_pixel(8'd200, 8'd5, 8'd3);

        // An unused mode passes the pixel through.
        reconfigure(WR_MODE, MODE_SPARE, 0, 0, 0, 0);
        send_pixel(8'd17, 8'd34, 8'd51);

        // Random part: bursts of pixels under random settings. The first third
        // has a slow receiver, the second a slow sender, the last no idling.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            if (random_sent < RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 54;
            end
            else if (random_sent < 2 * RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(3))
                0:       pct = ($urandom_range(1)) ? 1023 : ($urandom_range(1) ? 0 : 1000);
                1:       pct = PCT_BASE;
                default: pct = $urandom_range(1023);
            endcase
            // Dimensions are often shrunk below the current position here, which
            // forces the column to wrap on the next pixel, and the row when the column wraps.
            reconfigure(5'($urandom_range(31, 1)),
                        ($urandom_range(7) == 0) ? $urandom_range(MODE_SPARE, MODE_REGION + 1)
                                                 : $urandom_range(MODE_REGION),
                        $urandom_range(CH_NONE), pct, pick_dim(), pick_dim());

            burst = $urandom_range(40, 8);
            repeat (burst)
            begin
                // A quarter of the pixels are dark so that the times-20 region
                // gain and the gains do not always saturate.
                top = ($urandom_range(3) == 0) ? 15 : 255;
                send_pixel(PIX_W'($urandom_range(top)), PIX_W'($urandom_range(top)),
                           PIX_W'($urandom_range(top)));
                random_sent++;
            end
        end

        // Drain, then allow for the three-stage pipeline before judging.
        pixel.valid <= 1'b0;
        while (beats_checked < pixels_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pixels_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a run that hangs is reported as failed.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
